/* rtl/plnq_pkg.sv */
// shared constants and types for the point list neighbour query block
package plnq_pkg;

	localparam int MAX_STARS  = 1024;
	localparam int COORD_BITS = 24;
	localparam int IDX_W      = $clog2(MAX_STARS);
	localparam int CNT_W      = $clog2(MAX_STARS + 1);
	localparam int OPND_W     = COORD_BITS + 1;
	localparam int DIFF_W     = COORD_BITS + 2;
	localparam int MAG_W      = COORD_BITS;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int ENTRY_W    = 2 * COORD_BITS;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STARS);

	// item action codes
	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	// tag that travels with each operation through the distance unit
	typedef struct packed {
		logic             radius;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

endpackage

/* rtl/plnq_store.sv */
// star position memory, one write port and one registered read port
module plnq_store
	import plnq_pkg::*;
(
	input  logic               clk,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [ENTRY_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem_q [MAX_STARS];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/plnq_dist.sv */
// shared squared distance unit: abs difference, square, sum over three stages
module plnq_dist
	import plnq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     op_valid,
	input  dist_tag_t                op_tag,
	input  logic signed [OPND_W-1:0] xa,
	input  logic signed [OPND_W-1:0] xb,
	input  logic signed [OPND_W-1:0] ya,
	input  logic signed [OPND_W-1:0] yb,
	output logic                     res_valid,
	output dist_tag_t                res_tag,
	output logic [SQ_W-1:0]          sq_x,
	output logic [SQ_W-1:0]          sq_y,
	output logic [DIST_W-1:0]        dist_sq,
	output logic                     busy
);

	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        ax, ay;

	logic                vld_s1, vld_s2, vld_s3;
	dist_tag_t           tag_s1, tag_s2, tag_s3;
	logic [MAG_W-1:0]    mag_x_s1, mag_y_s1;
	logic [SQ_W-1:0]     sq_x_s2, sq_y_s2, sq_x_s3, sq_y_s3;
	logic [DIST_W-1:0]   dist_s3;

	assign dx = DIFF_W'(xa) - DIFF_W'(xb);
	assign dy = DIFF_W'(ya) - DIFF_W'(yb);
	assign ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= op_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1   <= op_tag;
		mag_x_s1 <= ax[MAG_W-1:0];
		mag_y_s1 <= ay[MAG_W-1:0];
		tag_s2   <= tag_s1;
		sq_x_s2  <= mag_x_s1 * mag_x_s1;
		sq_y_s2  <= mag_y_s1 * mag_y_s1;
		tag_s3   <= tag_s2;
		sq_x_s3  <= sq_x_s2;
		sq_y_s3  <= sq_y_s2;
		dist_s3  <= {1'b0, sq_x_s2} + {1'b0, sq_y_s2};
	end

	assign res_valid = vld_s3;
	assign res_tag   = tag_s3;
	assign sq_x      = sq_x_s3;
	assign sq_y      = sq_y_s3;
	assign dist_sq   = dist_s3;
	assign busy      = vld_s1 | vld_s2 | vld_s3;

endmodule

/* rtl/point_list_neighbor_query.sv */
// point list neighbour query: top level with sequencer, star store and distance unit
// clear and append give their result in the cycle after acceptance
// a query runs the radii through the distance unit, scans each held star, drains the unit, then registers its result
// the scan is bound by the single star memory read port and the
// shared distance unit; the block takes no item while a query runs
// reset: star count cleared, sequencer idle, no result pending; memory not cleared
module point_list_neighbor_query
	import plnq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  logic signed [23:0]    point_x,
	input  logic signed [23:0]    point_y,
	input  logic [23:0]           inner_radius,
	input  logic [23:0]           outer_radius,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [10:0]           stars_held,
	output logic                  append_dropped,
	output logic                  nearest_found,
	output logic [9:0]            nearest_index,
	output logic                  outer_found,
	output logic [9:0]            outer_index,
	output logic [10:0]           neighbor_count,
	output logic                  annulus_hit
);

	// one-hot sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RADIUS = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	// star count and scan pointer
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// captured query item
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [COORD_BITS-1:0]        rin_q, rout_q;

	// squared radii from the first pass through the distance unit
	logic [DIST_W-1:0] in2_q, out2_q;

	// running scan results
	logic              nfound_q, ofound_q, hit_q;
	logic [DIST_W-1:0] best_q, obest_q;
	logic [IDX_W-1:0]  nidx_q, oidx_q;
	logic [CNT_W-1:0]  ncount_q;

	// output register
	logic             out_valid_q;
	logic [CNT_W-1:0] stars_held_q, neighbor_count_q;
	logic             append_dropped_q, nearest_found_q, outer_found_q, annulus_hit_q;
	logic [IDX_W-1:0] nearest_index_q, outer_index_q;

	logic in_acc, out_free, full, fin_load, rd_issue, do_append;
	logic [CNT_W-1:0] next_count;

	// store and unit wiring
	logic [ENTRY_W-1:0] rd_data;
	logic               u_valid;
	dist_tag_t          u_tag;
	logic signed [OPND_W-1:0] u_xa, u_xb, u_ya, u_yb;
	logic               r_valid, u_busy;
	dist_tag_t          r_tag;
	logic [SQ_W-1:0]    r_sq_x, r_sq_y;
	logic [DIST_W-1:0]  r_dist;
	logic               star_res, beyond, in_outer;

	// a waiting result that is being taken this edge frees the register
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q >= MAX_CNT);
	assign do_append = in_acc && (action == ACT_APPEND) && !full;
	assign fin_load = (state_q == ST_FINISH) && out_free;
	assign rd_issue = (state_q == ST_SCAN) && (scan_idx_q < count_q);

	always_comb begin
		next_count = count_q;
		unique case (action)
			ACT_CLEAR:  next_count = '0;
			ACT_APPEND: next_count = full ? count_q : count_q + CNT_W'(1);
			default:    next_count = count_q;
		endcase
	end

	plnq_store u_store (
		.clk     (clk),
		.wr_en   (do_append),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({point_x, point_y}),
		.rd_en   (rd_issue),
		.rd_addr (scan_idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// radii go through the unit first as distances from zero
	always_comb begin
		if (state_q == ST_RADIUS) begin
			u_valid    = 1'b1;
			u_tag.radius = 1'b1;
			u_tag.idx  = '0;
			u_xa       = $signed({1'b0, rin_q});
			u_ya       = $signed({1'b0, rout_q});
			u_xb       = '0;
			u_yb       = '0;
		end else begin
			u_valid    = rd_vld_s1;
			u_tag.radius = 1'b0;
			u_tag.idx  = rd_idx_s1;
			u_xa       = OPND_W'(px_q);
			u_ya       = OPND_W'(py_q);
			u_xb       = OPND_W'($signed(rd_data[ENTRY_W-1:COORD_BITS]));
			u_yb       = OPND_W'($signed(rd_data[COORD_BITS-1:0]));
		end
	end

	plnq_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (u_valid),
		.op_tag    (u_tag),
		.xa        (u_xa),
		.xb        (u_xb),
		.ya        (u_ya),
		.yb        (u_yb),
		.res_valid (r_valid),
		.res_tag   (r_tag),
		.sq_x      (r_sq_x),
		.sq_y      (r_sq_y),
		.dist_sq   (r_dist),
		.busy      (u_busy)
	);

	assign star_res = r_valid && !r_tag.radius;
	assign beyond   = (r_dist > in2_q);
	assign in_outer = (r_dist < out2_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= next_count;
						if (action == ACT_QUERY) begin
							state_q    <= ST_RADIUS;
							scan_idx_q <= '0;
						end
					end
				end
				ST_RADIUS: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait until the last star has left the memory and the unit
					if (!rd_vld_s1 && !u_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read index is registered in step with the memory read
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (in_acc && (action == ACT_QUERY)) begin
			px_q   <= point_x;
			py_q   <= point_y;
			rin_q  <= inner_radius;
			rout_q <= outer_radius;
		end
		if (r_valid && r_tag.radius) begin
			in2_q  <= {1'b0, r_sq_x};
			out2_q <= {1'b0, r_sq_y};
		end
	end

	// running nearest, nearest beyond inner radius, count and annulus flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfound_q <= 1'b0;
			ofound_q <= 1'b0;
			hit_q    <= 1'b0;
			ncount_q <= '0;
		end else if (in_acc && (action == ACT_QUERY)) begin
			nfound_q <= 1'b0;
			ofound_q <= 1'b0;
			hit_q    <= 1'b0;
			ncount_q <= '0;
		end else if (star_res) begin
			if (!nfound_q || (r_dist < best_q)) begin
				nfound_q <= 1'b1;
			end
			if (beyond && (!ofound_q || (r_dist < obest_q))) begin
				ofound_q <= 1'b1;
			end
			if (in_outer) begin
				ncount_q <= ncount_q + CNT_W'(1);
			end
			if (beyond && in_outer) begin
				hit_q <= 1'b1;
			end
		end
	end

	// best distances and their indexes, strict less so the first one wins
	always_ff @(posedge clk) begin
		if (star_res) begin
			if (!nfound_q || (r_dist < best_q)) begin
				best_q <= r_dist;
				nidx_q <= r_tag.idx;
			end
			if (beyond && (!ofound_q || (r_dist < obest_q))) begin
				obest_q <= r_dist;
				oidx_q  <= r_tag.idx;
			end
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && (action != ACT_QUERY)) || fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && (action != ACT_QUERY)) begin
			stars_held_q     <= next_count;
			append_dropped_q <= (action == ACT_APPEND) && full;
			nearest_found_q  <= 1'b0;
			nearest_index_q  <= '0;
			outer_found_q    <= 1'b0;
			outer_index_q    <= '0;
			neighbor_count_q <= '0;
			annulus_hit_q    <= 1'b0;
		end else if (fin_load) begin
			stars_held_q     <= count_q;
			append_dropped_q <= 1'b0;
			nearest_found_q  <= nfound_q;
			nearest_index_q  <= nfound_q ? nidx_q : '0;
			outer_found_q    <= ofound_q;
			outer_index_q    <= ofound_q ? oidx_q : '0;
			neighbor_count_q <= ncount_q;
			annulus_hit_q    <= hit_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stars_held     = stars_held_q;
	assign append_dropped = append_dropped_q;
	assign nearest_found  = nearest_found_q;
	assign nearest_index  = nearest_index_q;
	assign outer_found    = outer_found_q;
	assign outer_index    = outer_index_q;
	assign neighbor_count = neighbor_count_q;
	assign annulus_hit    = annulus_hit_q;

endmodule

/* rtl/plnq_checker.sv */
// port level checks for the point list neighbour query block, bound to the top level
module plnq_checker
	import plnq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         action,
	input logic signed [23:0] point_x,
	input logic signed [23:0] point_y,
	input logic [23:0]        inner_radius,
	input logic [23:0]        outer_radius,
	input logic               out_valid,
	input logic               out_stall,
	input logic [10:0]        stars_held,
	input logic               append_dropped,
	input logic               nearest_found,
	input logic [9:0]         nearest_index,
	input logic               outer_found,
	input logic [9:0]         outer_index,
	input logic [10:0]        neighbor_count,
	input logic               annulus_hit
);

	// a clear item answers at once with an empty list
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_CLEAR) |=> out_valid && (stars_held == '0))
		else $error("clear did not give an empty list");

	// no nearest star means nothing else was found either
	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nearest_found |-> (nearest_index == '0) && !outer_found &&
			(outer_index == '0) && (neighbor_count == '0) && !annulus_hit)
		else $error("result fields set without a nearest star");

	// an annulus star is beyond the inner radius and inside the outer one
	a_annulus_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && annulus_hit |-> outer_found && (neighbor_count != '0))
		else $error("annulus hit without outer star or neighbour");

	// an append is only dropped when the list is full
	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && append_dropped |-> (stars_held == MAX_CNT))
		else $error("append dropped below capacity");

	// result stays valid and stars held, nearest index and neighbour count hold while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(stars_held) &&
			$stable(nearest_index) && $stable(neighbor_count))
		else $error("stalled item changed");

endmodule

bind point_list_neighbor_query plnq_checker u_plnq_checker (.*);
